// ===== rtl/core/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants of the block transposition cipher: register
// indexes, count width and the control word that travels with each block.
// ----------------------------------------------------------------------------
package btc_pkg;

  // Width of fill counts and of the key length register
  localparam int unsigned CNT_W = 5;

  // Configuration port geometry: four 64-bit registers at 8-byte spacing
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_KEY_LEN   = 2'd1;
  localparam logic [1:0] REG_KEY_LOW   = 2'd2;
  localparam logic [1:0] REG_KEY_HIGH  = 2'd3;

  // Mode register values
  localparam logic MODE_ENCRYPT = 1'b0;

  // Control word of one closed block
  typedef struct packed {
    logic [CNT_W-1:0] count;  // bytes received; later slots read as zero
    logic             eom;    // block was closed by end of message
  } blk_ctl_t;

endpackage

// ===== rtl/core/btc_front.sv =====
// ----------------------------------------------------------------------------
// btc_front
// Collects message bytes into a block and issues the closed block to the
// block queue when it is full or when the end of the message arrives.
// ----------------------------------------------------------------------------
module btc_front import btc_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_message_i,
  input  logic [CNT_W-1:0]            block_size_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output logic [MAX_KEY_LEN-1:0][7:0] q_data_o,
  output blk_ctl_t                    q_ctl_o
);

  localparam int unsigned IdxW = $clog2(MAX_KEY_LEN);

  logic [CNT_W-1:0]            fill_q, fill_d;
  logic [MAX_KEY_LEN-1:0][7:0] fill_buf_q;
  logic [CNT_W-1:0]            slot;
  logic [IdxW-1:0]             idx;
  logic [CNT_W-1:0]            count;
  logic                        accept;
  logic                        close;

  // Take a request whenever the queue has room for a closed block
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the slot when the block size shrank below the fill level
  assign slot  = (fill_q >= block_size_i) ? (block_size_i - CNT_W'(1)) : fill_q;
  assign idx   = slot[IdxW-1:0];
  assign count = slot + CNT_W'(1);
  assign close = (count == block_size_i) || end_of_message_i;

  // Issue the block with the incoming byte merged in
  always_comb begin
    q_data_o      = fill_buf_q;
    q_data_o[idx] = data_byte_i;
  end

  assign q_push_o      = accept && close;
  assign q_ctl_o.count = count;
  assign q_ctl_o.eom   = end_of_message_i;

  // Advance or restart the fill level
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = close ? '0 : count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Store the byte in its slot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill_buf_q[idx] <= data_byte_i;
    end
  end

endmodule

// ===== rtl/core/btc_queue.sv =====
// ----------------------------------------------------------------------------
// btc_queue
// Two-entry queue of closed blocks between the collecting front and the
// permuting back end.
// ----------------------------------------------------------------------------
module btc_queue import btc_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [MAX_KEY_LEN-1:0][7:0] push_data_i,
  input  blk_ctl_t                    push_ctl_i,
  input  logic                        pop_i,
  output logic                        full_o,
  output logic                        empty_o,
  output logic [MAX_KEY_LEN-1:0][7:0] head_data_o,
  output blk_ctl_t                    head_ctl_o
);

  logic [1:0][MAX_KEY_LEN-1:0][7:0] data_q;
  blk_ctl_t [1:0]                   ctl_q;
  logic                             wr_ptr_q, wr_ptr_d;
  logic                             rd_ptr_q, rd_ptr_d;
  logic [1:0]                       cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign head_data_o = data_q[rd_ptr_q];
  assign head_ctl_o  = ctl_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    priority if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold the block payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
      ctl_q[wr_ptr_q]  <= push_ctl_i;
    end
  end

endmodule

// ===== rtl/core/btc_back.sv =====
// ----------------------------------------------------------------------------
// btc_back
// Permutes the head block into the result buffer, one position per cycle
// through a shared rank unit, then drains the result buffer byte by byte.
// ----------------------------------------------------------------------------
module btc_back import btc_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mode_i,
  input  logic [CNT_W-1:0]            block_size_i,
  input  logic [MAX_KEY_LEN-1:0][7:0] key_chars_i,
  input  logic                        q_empty_i,
  input  logic [MAX_KEY_LEN-1:0][7:0] q_data_i,
  input  blk_ctl_t                    q_ctl_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        block_last_o
);

  localparam int unsigned IdxW = $clog2(MAX_KEY_LEN);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PERM  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [IdxW-1:0]             pos_q, pos_d;
  logic                        eom_q, eom_d;
  logic [MAX_KEY_LEN-1:0][7:0] res_q;
  logic [CNT_W-1:0]            rank;
  logic [7:0]                  cur_char;
  logic [IdxW-1:0]             rd_idx;
  logic [IdxW-1:0]             wr_idx;
  logic [7:0]                  pad_byte;
  logic                        last_pos;

  // Stable rank of the key character at the current position
  assign cur_char = key_chars_i[pos_q];
  always_comb begin
    rank = '0;
    for (int k = 0; k < MAX_KEY_LEN; k++) begin
      if ((CNT_W'(k) < block_size_i) &&
          ((key_chars_i[k] < cur_char) ||
           ((key_chars_i[k] == cur_char) && (IdxW'(k) < pos_q)))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  // Gather by rank when encrypting, scatter by rank when decrypting
  assign rd_idx   = (mode_i == MODE_ENCRYPT) ? rank[IdxW-1:0] : pos_q;
  assign wr_idx   = (mode_i == MODE_ENCRYPT) ? pos_q : rank[IdxW-1:0];
  assign pad_byte = (CNT_W'(rd_idx) < q_ctl_i.count) ? q_data_i[rd_idx] : 8'h00;
  assign last_pos = (CNT_W'(pos_q) == (block_size_i - CNT_W'(1)));

  // Sequence: permute the head block, release it, then drain
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    eom_d   = eom_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_PERM;
          pos_d   = '0;
        end
      end
      ST_PERM: begin
        if (last_pos) begin
          q_pop_o = 1'b1;
          eom_d   = q_ctl_i.eom;
          state_d = ST_DRAIN;
          pos_d   = '0;
        end else begin
          pos_d = pos_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (out_ready_i) begin
          if (last_pos) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      eom_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      eom_q   <= eom_d;
    end
  end

  // Write one permuted byte per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PERM) begin
      res_q[wr_idx] <= pad_byte;
    end
  end

  // Drive the result request from the result buffer
  assign out_valid_o  = (state_q == ST_DRAIN);
  assign out_byte_o   = res_q[pos_q];
  assign block_last_o = out_valid_o && eom_q && last_pos;

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("block released from an empty queue");

  a_pop_then_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (out_valid_o && pos_q == '0))
    else $error("drain did not start at position zero after release");

  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop_o))
    else $error("results shown without a released block");
`endif

endmodule

// ===== rtl/core/block_transposition_cipher.sv =====
// ----------------------------------------------------------------------------
// block_transposition_cipher
// Columnar block transposition: bytes are collected into blocks of one
// byte per key character and each block is emitted permuted by the key's ranks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one byte per request with an
//   end-of-message flag. A block closes when the block size is reached or when
//   a byte flagged end of message arrives; a short block is zero padded.
//   Output channel (out_valid_o/out_ready_i) returns a full block of bytes per
//   closed block; block_last_o marks the final byte of the message.
//   The APB port holds mode, key length and the two key words; write it only
//   while no block is in flight.
// Timing:
//   Bytes are taken one per cycle while the two-entry block queue has room.
//   A closed block waits in the queue until the back end is idle; the back end
//   then ranks and permutes it into the result buffer, one position per
//   cycle, releases it from the queue and drains the result buffer, and takes
//   the next block only after the drain ends.
// Reset clears the fill level, the queue and the result sequencer; the key
//   registers return to mode 0, key length 1, all-zero key.
// A stalled receiver holds the current result; the queue then fills and
//   in_ready_o drops.
// ----------------------------------------------------------------------------
module block_transposition_cipher import btc_pkg::*; #(
  parameter int unsigned MAX_KEY_LEN = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input byte channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              block_last_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic                        mode_q;
  logic [CNT_W-1:0]            key_len_q;
  logic [APB_DW-1:0]           key_low_q;
  logic [APB_DW-1:0]           key_high_q;
  logic [1:0]                  reg_idx;
  logic                        reg_wr;
  logic [CNT_W-1:0]            block_size;
  logic [MAX_KEY_LEN-1:0][7:0] key_chars;

  logic                        q_push;
  logic [MAX_KEY_LEN-1:0][7:0] q_push_data;
  blk_ctl_t                    q_push_ctl;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  logic [MAX_KEY_LEN-1:0][7:0] q_head_data;
  blk_ctl_t                    q_head_ctl;

  // Register file access
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ENCRYPT;
      key_len_q  <= CNT_W'(1);
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_MODE:     mode_q     <= pwdata[0];
        REG_KEY_LEN:  key_len_q  <= pwdata[CNT_W-1:0];
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:     prdata = {{(APB_DW-1){1'b0}}, mode_q};
      REG_KEY_LEN:  prdata = {{(APB_DW-CNT_W){1'b0}}, key_len_q};
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      default:      prdata = '0;
    endcase
  end

  // Clamp the block size into 1..MAX_KEY_LEN
  always_comb begin
    priority if (key_len_q == '0) begin
      block_size = CNT_W'(1);
    end else if (key_len_q > CNT_W'(MAX_KEY_LEN)) begin
      block_size = CNT_W'(MAX_KEY_LEN);
    end else begin
      block_size = key_len_q;
    end
  end

  // Split the key words into characters
  always_comb begin
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      key_chars[i] = (i < 8) ? key_low_q[(i%8)*8 +: 8] : key_high_q[(i%8)*8 +: 8];
    end
  end

  btc_front #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .block_size_i     (block_size),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (q_push_data),
    .q_ctl_o          (q_push_ctl)
  );

  btc_queue #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .push_ctl_i  (q_push_ctl),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_data_o (q_head_data),
    .head_ctl_o  (q_head_ctl)
  );

  btc_back #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .block_size_i (block_size),
    .key_chars_i  (key_chars),
    .q_empty_i    (q_empty),
    .q_data_i     (q_head_data),
    .q_ctl_i      (q_head_ctl),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .block_last_o (block_last_o)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_transposition_cipher. A queue-fed driver
// sends message bytes over the valid/ready input channel. A clocked monitor
// compares every returned byte against a local model of the key ranking
// and the block permutation. The run covers directed corner cases first,
// then random messages under changing key settings and idle patterns,
// including a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench import btc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_KEY_LEN  = 16;
  localparam int unsigned DRAIN_CYCLES = 4 * MAX_KEY_LEN + 8;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       eom;
  } plain_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       block_last;
  } cipher_out_t;

  // DUT ports
  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_byte_i      = '0;
  logic              end_of_message_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic [7:0]        out_byte_o;
  logic              block_last_o;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [APB_AW-1:0] paddr            = '0;
  logic [APB_DW-1:0] pwdata           = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Pending requests and expected cipher bytes
  plain_t      plain_q[$];
  cipher_out_t cipher_out_q[$];

  // Local copy of the block state and the key registers
  logic [7:0]  blk_buf [MAX_KEY_LEN];
  int unsigned fill_lvl    = 0;
  logic        cfg_mode    = MODE_ENCRYPT;
  logic [4:0]  cfg_key_len = 5'd1;
  logic [63:0] cfg_key_lo  = '0;
  logic [63:0] cfg_key_hi  = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_len    = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_cnt   = 0;

  block_transposition_cipher #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .block_last_o    (block_last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stable rank of key character j among the first n characters
  function automatic int unsigned key_rank(input int unsigned j, input int unsigned n);
    logic [127:0] keys;
    logic [7:0]   c;
    logic [7:0]   d;
    int unsigned  r;
    keys = {cfg_key_hi, cfg_key_lo};
    c = keys[8*j +: 8];
    r = 0;
    for (int unsigned k = 0; k < n; k++) begin
      d = keys[8*k +: 8];
      if (d < c || (d == c && k < j)) r++;
    end
    return r;
  endfunction

  // Collect one byte; on a closed block queue the permuted bytes
  function automatic void absorb_byte(input logic [7:0] b, input logic eom);
    int unsigned n;
    int unsigned idx;
    int unsigned cnt;
    int unsigned r;
    logic [7:0]  padded [MAX_KEY_LEN];
    logic [7:0]  perm   [MAX_KEY_LEN];
    n = 32'(cfg_key_len);
    if (n < 1) n = 1;
    if (n > MAX_KEY_LEN) n = MAX_KEY_LEN;
    idx = fill_lvl;
    if (idx >= n) idx = n - 1;
    blk_buf[idx] = b;
    cnt = idx + 1;
    if (cnt < n && !eom) begin
      fill_lvl = cnt;
      return;
    end
    for (int unsigned j = 0; j < n; j++) begin
      padded[j] = (j < cnt) ? blk_buf[j] : 8'h00;
    end
    for (int unsigned j = 0; j < n; j++) begin
      r = key_rank(j, n);
      if (cfg_mode == MODE_ENCRYPT) perm[j] = padded[r];
      else perm[r] = padded[j];
    end
    for (int unsigned j = 0; j < n; j++) begin
      cipher_out_q.push_back('{out_byte: perm[j], block_last: eom && (j == n - 1)});
    end
    fill_lvl = 0;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Driver: hold each request until taken, then offer the next or idle
  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    plain_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) absorb_byte(data_byte_i, end_of_message_i);
      if (!in_valid_i || in_ready_o) begin
        if (plain_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = plain_q.pop_front();
          in_valid_i       <= 1'b1;
          data_byte_i      <= nxt.data_byte;
          end_of_message_i <= nxt.eom;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_len != 0 && !hold_done) begin
        hold_left = hold_len;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_out
    cipher_out_t exp_out;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_out_q.size() == 0) begin
        report_mismatch($sformatf("result %02h/%0b with no expectation",
                                  out_byte_o, block_last_o));
      end else begin
        exp_out = cipher_out_q.pop_front();
        if (out_byte_o !== exp_out.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_byte_o, exp_out.out_byte));
        if (block_last_o !== exp_out.block_last)
          report_mismatch($sformatf("block_last %0b, expected %0b",
                                    block_last_o, exp_out.block_last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("block_transposition_cipher regression: fail");
      $finish;
    end
  end

  task automatic set_idle(input int unsigned tx, input int unsigned rx);
    @(negedge clk_i);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  task automatic push_plain(input logic [7:0] b, input logic eom);
    plain_q.push_back('{data_byte: b, eom: eom});
  endtask

  // Wait for all requests and results, then let the back end settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (plain_q.size() != 0 || in_valid_i || cipher_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Two-phase register write; mirror the value once it lands
  task automatic apb_write(input logic [1:0] reg_idx, input logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_MODE:    cfg_mode    = value[0];
      REG_KEY_LEN: cfg_key_len = value[4:0];
      REG_KEY_LOW: cfg_key_lo  = value[63:0];
      default:     cfg_key_hi  = value[63:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic m, input logic [4:0] len,
                              input logic [63:0] lo, input logic [63:0] hi);
    apb_write(REG_MODE, {{(APB_DW-1){1'b0}}, m});
    apb_write(REG_KEY_LEN, {{(APB_DW-5){1'b0}}, len});
    apb_write(REG_KEY_LOW, lo);
    apb_write(REG_KEY_HIGH, hi);
  endtask

  // Pick a key style and a block size, out-of-range sizes included
  task automatic random_config(input bit pressure);
    logic [127:0] key;
    logic [4:0]   len;
    logic [7:0]   base;
    int unsigned  style;
    style = $urandom_range(0, 3);
    base  = 8'($urandom_range(0, 255));
    for (int i = 0; i < 16; i++) begin
      case (style)
        0:       key[8*i +: 8] = 8'($urandom_range(0, 255));
        1:       key[8*i +: 8] = base;
        2:       key[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
        default: key[8*i +: 8] = 8'($urandom_range(8'h7A, 8'hFF));
      endcase
    end
    case ($urandom_range(0, 9))
      0:       len = 5'd0;
      1:       len = 5'd1;
      2:       len = 5'd16;
      3:       len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(2, 15));
    endcase
    if (pressure) len = 5'd4;
    write_config(1'($urandom_range(0, 1)), len, key[63:0], key[127:64]);
  endtask

  // Queue random messages; optionally leave the last one open
  task automatic gen_messages(input int unsigned n_items, input bit close_last);
    int unsigned made;
    int unsigned len;
    bit          noisy;
    logic [7:0]  b;
    made = 0;
    while (made < n_items) begin
      len   = $urandom_range(1, 40);
      noisy = ($urandom_range(0, 99) < 15);
      for (int unsigned i = 0; i < len && made < n_items; i++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        if (noisy) push_plain(b, $urandom_range(0, 3) == 0);
        else push_plain(b, (i == len - 1) || (made + 1 == n_items));
        made++;
      end
    end
    if (!close_last) plain_q[$].eom = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idle(10, 68);

    // Reset settings: one-byte blocks, closed by size and by end of message
    push_plain(8'h00, 1'b0);
    push_plain(8'hFF, 1'b1);
    wait_drained();

    // Encrypt with a distinct key, full block then short padded block
    write_config(1'b0, 5'd4, 64'h4243_4144, 64'h0);
    push_plain(8'h00, 1'b0);
    push_plain(8'hFF, 1'b0);
    push_plain(8'h55, 1'b0);
    push_plain(8'hAA, 1'b0);
    push_plain(8'h5A, 1'b1);
    wait_drained();

    // Decrypt with the same key, short final block
    apb_write(REG_MODE, {{(APB_DW-1){1'b0}}, 1'b1});
    push_plain(8'h11, 1'b0);
    push_plain(8'h22, 1'b1);
    wait_drained();

    // Largest block, tied key characters and bytes at 'z' and above
    write_config(1'b0, 5'd16, 64'h7A7A_7A7A_7A7A_7A7A, 64'hFFFF_FFFF_0000_0000);
    push_plain(8'h01, 1'b0);
    push_plain(8'h80, 1'b0);
    push_plain(8'hFE, 1'b1);
    wait_drained();

    // Zero key length acts as one
    apb_write(REG_KEY_LEN, '0);
    push_plain(8'h3C, 1'b0);
    wait_drained();

    // Oversized key length saturates; then shrink below the fill level
    apb_write(REG_KEY_LEN, 64'd31);
    push_plain(8'hC3, 1'b0);
    push_plain(8'h7E, 1'b0);
    wait_drained();
    apb_write(REG_KEY_LEN, 64'd1);
    push_plain(8'h99, 1'b0);
    wait_drained();

    // Mode and key changed while a block is half collected
    write_config(1'b0, 5'd8, 64'h0102_0304_0506_0708, 64'h0);
    push_plain(8'hA0, 1'b0);
    push_plain(8'hA1, 1'b0);
    push_plain(8'hA2, 1'b0);
    wait_drained();
    apb_write(REG_MODE, {{(APB_DW-1){1'b0}}, 1'b1});
    apb_write(REG_KEY_LOW, 64'h6D61_6368_696E_6573);
    for (int i = 0; i < 5; i++) push_plain(8'(8'hB0 + i), 1'b0);
    wait_drained();

    // Random messages under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       set_idle(10, 68);
        1:       set_idle(68, 10);
        default: set_idle(0, 0);
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        if (phase == 2 && sub == 0) begin
          // Back up the input: hold the receiver while requests keep coming
          random_config(1'b1);
          @(negedge clk_i);
          hold_len = HOLD_CYCLES;
          gen_messages(40, 1'b1);
        end else begin
          random_config(1'b0);
          gen_messages(7, (phase == 2 && sub == 2) || $urandom_range(0, 2) == 0);
        end
        wait_drained();
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("block_transposition_cipher regression: pass");
    end else begin
      $display("block_transposition_cipher regression: fail");
    end
    $finish;
  end

endmodule
